// ----- hdl/gpm_pkg.sv -----
// shared types, constants and register codes for the path matcher
package gpm_pkg;

  // pattern capacity and register file layout
  localparam int PATTERN_MAX_DEF = 32;
  localparam int PAT_LIMIT       = 32;
  localparam int WORD_BYTES      = 8;
  localparam int NUM_WORDS       = 4;
  localparam int DATA_W          = 64;
  localparam int ADDR_W          = 6;
  localparam int IDX_W           = ADDR_W - 3;
  localparam int LEN_W           = 6;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  // glob wildcard characters
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // register indexes
  localparam logic [IDX_W-1:0] REG_WORD0  = 3'd0;
  localparam logic [IDX_W-1:0] REG_WORD1  = 3'd1;
  localparam logic [IDX_W-1:0] REG_WORD2  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WORD3  = 3'd3;
  localparam logic [IDX_W-1:0] REG_LENGTH = 3'd4;

  typedef struct packed {
    logic [7:0] path_char;
    logic       char_present;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic glob_mode;
  } out_item_t;

  typedef struct packed {
    logic char_present;
    logic last_char;
  } item_ctrl_t;

  typedef struct packed {
    logic glob;
    logic len_zero;
  } mode_t;

endpackage

// ----- hdl/gpm_cfg.sv -----
// pattern register file and the masks derived from the pattern
module gpm_cfg #(
  parameter int PATTERN_MAX = gpm_pkg::PATTERN_MAX_DEF,
  localparam int CAP = (PATTERN_MAX < gpm_pkg::PAT_LIMIT) ? PATTERN_MAX : gpm_pkg::PAT_LIMIT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [gpm_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [gpm_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [gpm_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output logic [CAP*8-1:0]            pat_bytes,
  output logic [CAP-1:0]              len_mask,
  output logic [CAP-1:0]              star_r,
  output logic [CAP-1:0]              qmark_r,
  output logic [CAP-1:0]              last_mask_r,
  output logic [CAP:0]                end_mask_r,
  output logic [CAP:0]                start_r,
  output gpm_pkg::mode_t              mode_r,
  output logic                        restart
);
  import gpm_pkg::*;

  logic [DATA_W-1:0] pattern_r [NUM_WORDS];
  logic [LEN_W-1:0]  length_r;
  logic [IDX_W-1:0]  reg_idx;
  logic              wr_en;
  logic [LEN_W-1:0]  n_eff;
  logic [CAP-1:0]    star_live;
  logic [CAP-1:0]    qmark_live;
  logic [CAP-1:0]    last_live;
  logic [CAP:0]      end_live;
  logic [CAP:0]      start_one;
  logic [CAP:0]      star_ext;
  logic [CAP:0]      seed;
  logic [CAP+1:0]    seed_sum;
  logic [CAP+1:0]    seed_carry;
  logic              glob_live;

  assign reg_idx    = cfg_paddr[ADDR_W-1:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // a write to a defined register restarts the current path
  assign restart = wr_en && (reg_idx <= REG_LENGTH);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        pattern_r[w] <= '0;
      end
      length_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx) inside
        REG_WORD0, REG_WORD1, REG_WORD2, REG_WORD3: begin
          pattern_r[reg_idx[1:0]] <= cfg_pwdata;
        end
        REG_LENGTH: begin
          length_r <= cfg_pwdata[LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx) inside
      REG_WORD0, REG_WORD1, REG_WORD2, REG_WORD3: cfg_prdata = pattern_r[reg_idx[1:0]];
      REG_LENGTH: cfg_prdata = {{(DATA_W-LEN_W){1'b0}}, length_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // pattern bytes laid out flat
  for (genvar i = 0; i < CAP; i++) begin : g_bytes
    assign pat_bytes[8*i +: 8] = pattern_r[i / WORD_BYTES][(i % WORD_BYTES)*8 +: 8];
  end

  // length clamp and per-position masks
  always_comb begin
    n_eff = (length_r > LEN_W'(CAP)) ? LEN_W'(CAP) : length_r;
    for (int i = 0; i < CAP; i++) begin
      len_mask[i]   = LEN_W'(i) < n_eff;
      star_live[i]  = len_mask[i] && (pat_bytes[8*i +: 8] == CH_STAR);
      qmark_live[i] = len_mask[i] && (pat_bytes[8*i +: 8] == CH_QMARK);
      last_live[i]  = n_eff == LEN_W'(i + 1);
    end
    for (int i = 0; i <= CAP; i++) begin
      end_live[i] = n_eff == LEN_W'(i);
    end
    glob_live = |(star_live | qmark_live);
  end

  // start vector: position 0 closed over runs of stars (carry chain of an add)
  always_comb begin
    start_one  = {{CAP{1'b0}}, 1'b1};
    star_ext   = {1'b0, star_live};
    seed       = start_one & star_ext;
    seed_sum   = {1'b0, seed} + {1'b0, star_ext};
    seed_carry = seed_sum ^ {1'b0, seed} ^ {1'b0, star_ext};
  end

  // derived values, registered for the back end
  always_ff @(posedge clk) begin
    star_r          <= star_live;
    qmark_r         <= qmark_live;
    last_mask_r     <= last_live;
    end_mask_r      <= end_live;
    start_r         <= glob_live ? (start_one | seed_carry[CAP:0]) : '0;
    mode_r.glob     <= glob_live;
    mode_r.len_zero <= n_eff == '0;
  end

endmodule

// ----- hdl/gpm_front.sv -----
// front end: takes path bytes and classifies them against every active pattern byte
module gpm_front #(
  parameter int PATTERN_MAX = gpm_pkg::PATTERN_MAX_DEF,
  localparam int CAP = (PATTERN_MAX < gpm_pkg::PAT_LIMIT) ? PATTERN_MAX : gpm_pkg::PAT_LIMIT
) (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gpm_pkg::in_item_t    in_data,
  input  logic [CAP*8-1:0]     pat_bytes,
  input  logic [CAP-1:0]       len_mask,
  output logic                 push_valid,
  input  logic                 push_ready,
  output logic [CAP-1:0]       push_mask,
  output gpm_pkg::item_ctrl_t  push_ctrl
);
  import gpm_pkg::*;

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  // byte equality against each active pattern position
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      push_mask[i] = len_mask[i] && (pat_bytes[8*i +: 8] == in_data.path_char);
    end
    push_ctrl.char_present = in_data.char_present;
    push_ctrl.last_char    = in_data.last_char;
  end

endmodule

// ----- hdl/gpm_queue.sv -----
// short queue of classified bytes between front and back
module gpm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  import gpm_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [W-1:0]     mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = count_r != CNT_W'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

endmodule

// ----- hdl/gpm_back.sv -----
// back end: advances the position vector per byte and emits one result per path
module gpm_back #(
  parameter int PATTERN_MAX = gpm_pkg::PATTERN_MAX_DEF,
  localparam int CAP = (PATTERN_MAX < gpm_pkg::PAT_LIMIT) ? PATTERN_MAX : gpm_pkg::PAT_LIMIT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  logic [CAP-1:0]       pop_mask,
  input  gpm_pkg::item_ctrl_t  pop_ctrl,
  input  logic [CAP-1:0]       star_r,
  input  logic [CAP-1:0]       qmark_r,
  input  logic [CAP-1:0]       last_mask_r,
  input  logic [CAP:0]         end_mask_r,
  input  logic [CAP:0]         start_r,
  input  gpm_pkg::mode_t       mode_r,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gpm_pkg::out_item_t   out_data
);
  import gpm_pkg::*;

  logic [CAP:0]   reach_r;
  logic [CAP:0]   reach_nxt;
  logic           found_r;
  logic           found_nxt;
  logic           fresh_r;
  logic           out_valid_r;
  out_item_t      out_data_r;
  logic [CAP:0]   base;
  logic           base_found;
  logic [CAP-1:0] stay;
  logic [CAP-1:0] adv;
  logic [CAP:0]   nv;
  logic [CAP:0]   star_ext;
  logic [CAP:0]   seed;
  logic [CAP+1:0] seed_sum;
  logic [CAP+1:0] seed_carry;
  logic [CAP:0]   glob_next;
  logic [CAP-1:0] lit_next;
  logic           match;
  logic           pop_fire;

  // a path end waits only for the result register
  assign pop_ready = !pop_ctrl.last_char || !out_valid_r || out_ready;
  assign pop_fire  = pop_valid && pop_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one step of the glob or substring update
  always_comb begin
    base       = fresh_r ? start_r : reach_r;
    base_found = !fresh_r && found_r;

    // glob: stars hold, others advance, then close over star runs
    stay       = base[CAP-1:0] & star_r;
    adv        = base[CAP-1:0] & (qmark_r | pop_mask) & ~star_r;
    nv         = {1'b0, stay} | ({1'b0, adv} << 1);
    star_ext   = {1'b0, star_r};
    seed       = nv & star_ext;
    seed_sum   = {1'b0, seed} + {1'b0, star_ext};
    seed_carry = seed_sum ^ {1'b0, seed} ^ {1'b0, star_ext};
    glob_next  = nv | seed_carry[CAP:0];

    // literal: shift-and
    lit_next = ((base[CAP-1:0] << 1) | CAP'(1)) & pop_mask;

    if (!pop_ctrl.char_present) begin
      reach_nxt = base;
      found_nxt = base_found;
    end else if (mode_r.glob) begin
      reach_nxt = glob_next;
      found_nxt = base_found;
    end else begin
      reach_nxt = {1'b0, lit_next};
      found_nxt = base_found || (|(lit_next & last_mask_r));
    end

    match = mode_r.glob ? (|(reach_nxt & end_mask_r)) : (mode_r.len_zero || found_nxt);
  end

  // path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= 1'b1;
    end else if (restart) begin
      fresh_r <= 1'b1;
    end else if (pop_fire) begin
      fresh_r <= pop_ctrl.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      reach_r <= reach_nxt;
      found_r <= found_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_fire && pop_ctrl.last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire && pop_ctrl.last_char) begin
      out_data_r.matched   <= match;
      out_data_r.glob_mode <= mode_r.glob;
    end
  end

  a_path_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_fire && pop_ctrl.last_char) |=> out_valid_r)
    else $error("path end gave no result");

  a_path_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_fire && pop_ctrl.last_char) |=> fresh_r)
    else $error("path state not restarted after a result");

  a_literal_width: assert property (@(posedge clk) disable iff (!rst_n)
    (!fresh_r && !mode_r.glob) |-> !reach_r[CAP])
    else $error("substring vector spilled past the pattern");

endmodule

// ----- hdl/glob_or_substring_path_match_top.sv -----
// top level of the path matcher: glob or substring match of a streamed path
// a path end passes through the queue and then into the result register
// throughput: one path byte per cycle; the result register only stalls path ends
// the byte compare in the front and the star-run carry add in the back set the cycle
// reset: synchronous active low; pattern registers and length clear to zero,
// queue empties, result channel goes idle, path state returns to its start
module glob_or_substring_path_match_top #(
  parameter int PATTERN_MAX = gpm_pkg::PATTERN_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gpm_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gpm_pkg::out_item_t          out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [gpm_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [gpm_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [gpm_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import gpm_pkg::*;

  localparam int CAP  = (PATTERN_MAX < PAT_LIMIT) ? PATTERN_MAX : PAT_LIMIT;
  localparam int QW   = CAP + $bits(item_ctrl_t);

  logic [CAP*8-1:0] pat_bytes;
  logic [CAP-1:0]   len_mask;
  logic [CAP-1:0]   star_r;
  logic [CAP-1:0]   qmark_r;
  logic [CAP-1:0]   last_mask_r;
  logic [CAP:0]     end_mask_r;
  logic [CAP:0]     start_r;
  mode_t            mode_r;
  logic             restart;
  logic             push_valid;
  logic             push_ready;
  logic [CAP-1:0]   push_mask;
  item_ctrl_t       push_ctrl;
  logic             pop_valid;
  logic             pop_ready;
  logic [QW-1:0]    pop_data;
  logic [CAP-1:0]   pop_mask;
  item_ctrl_t       pop_ctrl;

  // configuration registers
  gpm_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .pat_bytes   (pat_bytes),
    .len_mask    (len_mask),
    .star_r      (star_r),
    .qmark_r     (qmark_r),
    .last_mask_r (last_mask_r),
    .end_mask_r  (end_mask_r),
    .start_r     (start_r),
    .mode_r      (mode_r),
    .restart     (restart)
  );

  // classify each request
  gpm_front #(.PATTERN_MAX(PATTERN_MAX)) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .pat_bytes  (pat_bytes),
    .len_mask   (len_mask),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_mask  (push_mask),
    .push_ctrl  (push_ctrl)
  );

  // decoupling queue
  gpm_queue #(.W(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_mask, push_ctrl}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_mask = pop_data[QW-1 -: CAP];
  assign pop_ctrl = pop_data[$bits(item_ctrl_t)-1:0];

  // match engine and result register
  gpm_back #(.PATTERN_MAX(PATTERN_MAX)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_mask    (pop_mask),
    .pop_ctrl    (pop_ctrl),
    .star_r      (star_r),
    .qmark_r     (qmark_r),
    .last_mask_r (last_mask_r),
    .end_mask_r  (end_mask_r),
    .start_r     (start_r),
    .mode_r      (mode_r),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
